[hw/rtl/dcfir_pkg.sv]
package dcfir_pkg;

  localparam int TAP_COUNT_DEF   = 29;
  localparam int SAMPLE_BITS_DEF = 20;
  localparam int COEFF_BITS_DEF  = 16;
  localparam int ROM_SIZE        = 64;

  // request function codes
  localparam logic [1:0] FUNC_IR    = 2'd0;
  localparam logic [1:0] FUNC_RED   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic shift;
    logic sel;
    logic clr;
  } cell_ctrl_t;

  typedef struct packed {
    logic clr_acc;
    logic mul_en;
  } mac_ctrl_t;

  // Symmetric low-pass taps in Q1.15; taps past the 29th are zero.
  localparam int COEFF_ROM [ROM_SIZE] = '{
    0: -51,   1: -72,   2: -108,  3: -145,  4: -156,  5: -99,   6: 72,
    7: 389,   8: 864,   9: 1474,  10: 2161, 11: 2843, 12: 3423, 13: 3813,
    14: 3950, 15: 3813, 16: 3423, 17: 2843, 18: 2161, 19: 1474, 20: 864,
    21: 389,  22: 72,   23: -99,  24: -156, 25: -145, 26: -108, 27: -72,
    28: -51,  default: 0
  };

  // Rescale a Q1.15 tap to Q1.(cb-1), rounding half up when narrowing.
  function automatic int coeff_at(int k, int cb);
    int c;
    c = (k < ROM_SIZE) ? COEFF_ROM[k] : 0;
    if (cb >= 16) begin
      return c * (1 << (cb - 16));
    end
    return (c * (1 << (cb - 1)) + 16384) >>> 15;
  endfunction

endpackage

[hw/rtl/dcfir_cell.sv]
module dcfir_cell #(
  parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dcfir_pkg::cell_ctrl_t         ctrl,
  input  logic signed [SAMPLE_BITS-1:0] d_in,
  output logic signed [SAMPLE_BITS-1:0] d_out
);

  logic signed [SAMPLE_BITS-1:0] ir_smp;
  logic signed [SAMPLE_BITS-1:0] red_smp;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      ir_smp  <= '0;
      red_smp <= '0;
    end else if (ctrl.shift) begin
      if (ctrl.sel) begin
        red_smp <= d_in;
      end else begin
        ir_smp <= d_in;
      end
    end
  end

  // hand the selected channel's sample on to the next cell
  assign d_out = ctrl.sel ? red_smp : ir_smp;

endmodule

[hw/rtl/dcfir_mac.sv]
module dcfir_mac #(
  parameter int TAP_COUNT   = dcfir_pkg::TAP_COUNT_DEF,
  parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = dcfir_pkg::COEFF_BITS_DEF,
  parameter int IDX_W       = $clog2(TAP_COUNT)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dcfir_pkg::mac_ctrl_t          ctrl,
  input  logic [IDX_W-1:0]              tap_idx,
  input  logic signed [SAMPLE_BITS-1:0] operand,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);
  localparam int FRAC   = COEFF_BITS - 1;
  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1) << (FRAC - 1);
  localparam logic signed [ACC_W:0] MAXV =
    (ACC_W+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W:0] MINV =
    (ACC_W+1)'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  logic signed [COEFF_BITS-1:0] coeff_rom [TAP_COUNT];
  logic signed [PROD_W-1:0]     prod;
  logic                         prod_vld;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W:0]        rnd_sum;
  logic signed [ACC_W:0]        rnd_q;

  for (genvar g = 0; g < TAP_COUNT; g++) begin : g_rom
    assign coeff_rom[g] = COEFF_BITS'(dcfir_pkg::coeff_at(g, COEFF_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr_acc) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(coeff_rom[tap_idx]) * PROD_W'(operand);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr_acc) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, then clamp to the sample range
  assign rnd_sum = (ACC_W+1)'(acc) + RND_HALF;
  assign rnd_q   = rnd_sum >>> FRAC;

  always_comb begin
    priority if (rnd_q > MAXV) begin
      result = MAXV[SAMPLE_BITS-1:0];
    end else if (rnd_q < MINV) begin
      result = MINV[SAMPLE_BITS-1:0];
    end else begin
      result = rnd_q[SAMPLE_BITS-1:0];
    end
  end

endmodule

[hw/rtl/dual_channel_fir_lowpass.sv]
// Channel   Handshake               Payload
// request   req_valid / req_stall   func[1:0], sample[SAMPLE_BITS-1:0] signed
// result    res_valid / res_stall   channel, filtered[SAMPLE_BITS-1:0] signed
//
// A filter request, once accepted, runs one multiply per tap on the single shared
// multiplier while the sequencer is in S_MAC, then adds the last product in S_ACC
// and loads the output register in S_DONE, then returns to idle for the next request.
// A clear or unused request never leaves the idle state. Reset (rst, synchronous) zeroes both
// histories in every cell at once. A stalled full output register holds the
// sequencer; the next request is taken while a result still waits there.
module dual_channel_fir_lowpass #(
  parameter int TAP_COUNT   = dcfir_pkg::TAP_COUNT_DEF,
  parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = dcfir_pkg::COEFF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    func,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          channel,
  output logic signed [SAMPLE_BITS-1:0] filtered
);

  localparam int HIST_LEN = TAP_COUNT - 1;
  localparam int IDX_W    = $clog2(TAP_COUNT);

  dcfir_pkg::state_t     state, state_next;
  logic [IDX_W-1:0]      tap_idx, tap_idx_next;
  logic signed [SAMPLE_BITS-1:0] smp_reg;
  logic                  chan_reg;
  logic                  req_acc;
  logic                  res_load;
  dcfir_pkg::cell_ctrl_t cell_ctrl;
  dcfir_pkg::mac_ctrl_t  mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] link [HIST_LEN];
  logic signed [SAMPLE_BITS-1:0] chain_head;
  logic signed [SAMPLE_BITS-1:0] operand;
  logic signed [SAMPLE_BITS-1:0] mac_result;

  assign req_stall = (state != dcfir_pkg::S_IDLE);
  assign req_acc   = req_valid && !req_stall;

  // Hold the sample and channel of the request in flight.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      smp_reg  <= sample;
      chan_reg <= func[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dcfir_pkg::S_IDLE;
      tap_idx <= '0;
    end else begin
      state   <= state_next;
      tap_idx <= tap_idx_next;
    end
  end

  // Sequencer: walk the tap index down from HIST_LEN. While it is above zero
  // the selected history rotates once round the chain, its last cell feeding
  // the multiplier; at zero the new sample goes into the head cell and the
  // oldest sample drops off the end.
  always_comb begin
    state_next         = state;
    tap_idx_next       = tap_idx;
    res_load           = 1'b0;
    cell_ctrl.shift    = 1'b0;
    cell_ctrl.sel      = chan_reg;
    cell_ctrl.clr      = 1'b0;
    mac_ctrl.clr_acc   = 1'b0;
    mac_ctrl.mul_en    = 1'b0;
    unique case (state)
      dcfir_pkg::S_IDLE: begin
        if (req_acc) begin
          if (func == dcfir_pkg::FUNC_CLEAR) begin
            cell_ctrl.clr = 1'b1;
          end else if (func == dcfir_pkg::FUNC_IR || func == dcfir_pkg::FUNC_RED) begin
            mac_ctrl.clr_acc = 1'b1;
            tap_idx_next     = IDX_W'(HIST_LEN);
            state_next       = dcfir_pkg::S_MAC;
          end
        end
      end
      dcfir_pkg::S_MAC: begin
        cell_ctrl.shift = 1'b1;
        mac_ctrl.mul_en = 1'b1;
        if (tap_idx == '0) begin
          state_next = dcfir_pkg::S_ACC;
        end else begin
          tap_idx_next = tap_idx - IDX_W'(1);
        end
      end
      dcfir_pkg::S_ACC: begin
        state_next = dcfir_pkg::S_DONE;
      end
      dcfir_pkg::S_DONE: begin
        // wait for the output register to free up
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = dcfir_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dcfir_pkg::S_IDLE;
      end
    endcase
  end

  // Close the chain into a ring while rotating; insert the sample at the head.
  assign chain_head = (tap_idx == '0) ? smp_reg : link[HIST_LEN-1];
  assign operand    = (tap_idx == '0) ? smp_reg : link[HIST_LEN-1];

  for (genvar g = 0; g < HIST_LEN; g++) begin : g_cell
    if (g == 0) begin : g_head
      dcfir_cell #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctrl (cell_ctrl),
        .d_in (chain_head),
        .d_out(link[g])
      );
    end else begin : g_body
      dcfir_cell #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctrl (cell_ctrl),
        .d_in (link[g-1]),
        .d_out(link[g])
      );
    end
  end

  dcfir_mac #(
    .TAP_COUNT  (TAP_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEFF_BITS (COEFF_BITS),
    .IDX_W      (IDX_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .tap_idx(tap_idx),
    .operand(operand),
    .result (mac_result)
  );

  // Output register: drop the result once taken, load a new one when free.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      channel  <= chan_reg;
      filtered <= mac_result;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_filter: assert property (@(posedge clk) disable iff (rst)
    (req_acc && (func == dcfir_pkg::FUNC_IR || func == dcfir_pkg::FUNC_RED))
      |=> req_stall)
    else $error("filter request accepted but block not busy");

  a_channel_tag: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> (channel == chan_reg))
    else $error("result carries the wrong channel");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (req_acc && func == dcfir_pkg::FUNC_CLEAR) |=> (link[HIST_LEN-1] == '0))
    else $error("history not cleared");
`endif

endmodule

[dv/fir_result_checker.sv]
module fir_result_checker
  import dcfir_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  logic                              req_stall,
  input  logic [1:0]                        func,
  input  logic signed [SAMPLE_BITS_DEF-1:0] sample,
  input  logic                              res_valid,
  input  logic                              res_stall,
  input  logic                              channel,
  input  logic signed [SAMPLE_BITS_DEF-1:0] filtered,
  output int                                pending_outputs,
  output int                                mismatch_count
);

  localparam int     HIST_DEPTH = TAP_COUNT_DEF - 1;
  localparam int     FRAC_BITS  = COEFF_BITS_DEF - 1;
  localparam longint OUT_MAX    = (64'sd1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
  localparam longint OUT_MIN    = -(64'sd1 <<< (SAMPLE_BITS_DEF - 1));

  // low-pass taps, Q1.15
  localparam int LOWPASS_TAPS [TAP_COUNT_DEF] = '{
    -51, -72, -108, -145, -156, -99, 72, 389, 864, 1474,
    2161, 2843, 3423, 3813, 3950, 3813, 3423, 2843, 2161, 1474,
    864, 389, 72, -99, -156, -145, -108, -72, -51
  };

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  typedef struct {
    logic    chan;
    sample_t value;
  } filter_output_t;

  sample_t        history [2][HIST_DEPTH];
  filter_output_t expected_outputs [$];
  filter_output_t oldest;

  task automatic report_mismatch(input string msg);
    $display("[%0t] fir check: %s", $time, msg);
    mismatch_count++;
  endtask

  // Sum over the new sample and the channel history, then shift the history.
  task automatic filter_sample(input logic chan, input sample_t x);
    longint acc;
    longint y;
    int     k;
    acc = longint'(LOWPASS_TAPS[0]) * longint'(x);
    for (k = 1; k < TAP_COUNT_DEF; k++) begin
      acc += longint'(LOWPASS_TAPS[k]) * longint'(history[chan][k-1]);
    end
    for (k = HIST_DEPTH - 1; k > 0; k--) begin
      history[chan][k] = history[chan][k-1];
    end
    history[chan][0] = x;
    y = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (y > OUT_MAX) y = OUT_MAX;
    if (y < OUT_MIN) y = OUT_MIN;
    expected_outputs.push_back('{chan: chan, value: sample_t'(y)});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (history[c, k]) history[c][k] = '0;
      expected_outputs.delete();
      mismatch_count = 0;
    end else begin
      // compare before predicting: a result never belongs to this edge's request
      if (res_valid && !res_stall) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("unexpected result channel %0d filtered %0d",
                                    channel, filtered));
        end else begin
          oldest = expected_outputs.pop_front();
          if (channel !== oldest.chan)
            report_mismatch($sformatf("channel %0d, want %0d", channel, oldest.chan));
          if (filtered !== oldest.value)
            report_mismatch($sformatf("filtered %0d on channel %0d, want %0d",
                                      filtered, oldest.chan, oldest.value));
        end
      end
      if (req_valid && !req_stall) begin
        case (func)
          FUNC_IR:    filter_sample(1'b0, sample);
          FUNC_RED:   filter_sample(1'b1, sample);
          FUNC_CLEAR: foreach (history[c, k]) history[c][k] = '0;
          default:    ;
        endcase
      end
    end
    pending_outputs = expected_outputs.size();
  end

endmodule

[dv/testbench.sv]
module testbench;
  import dcfir_pkg::*;

  // the one code the package leaves unnamed: the block must drop it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int SAMPLE_MAX     = (1 << (SAMPLE_BITS_DEF - 1)) - 1;
  localparam int SAMPLE_MIN     = -(1 << (SAMPLE_BITS_DEF - 1));
  // taps 6 to 22 carry positive weights, the rest negative
  localparam int POS_TAP_FIRST  = 6;
  localparam int POS_TAP_LAST   = 22;
  localparam int PHASE_REQUESTS = 633;
  localparam int TAIL_CYCLES    = TAP_COUNT_DEF + 12;
  localparam int CYCLE_LIMIT    = 1_000_000;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    req_valid = 1'b0;
  logic    req_stall;
  logic    [1:0] func = FUNC_IR;
  sample_t sample    = '0;
  logic    res_valid;
  logic    res_stall = 1'b0;
  logic    channel;
  sample_t filtered;

  int pending_outputs;
  int mismatch_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int requests_sent  = 0;
  int cycle_count    = 0;

  always #5 clk = ~clk;

  dual_channel_fir_lowpass uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .sample    (sample),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .channel   (channel),
    .filtered  (filtered)
  );

  fir_result_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .func            (func),
    .sample          (sample),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .channel         (channel),
    .filtered        (filtered),
    .pending_outputs (pending_outputs),
    .mismatch_count  (mismatch_count)
  );

  // Stall the result side at random; the percentage changes per phase.
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: end the run if the block hangs or a result never turns up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one request and hold it until accepted. During an idle gap drop
  // valid and scramble the payload, which the block must ignore.
  task automatic send_request(input logic [1:0] f, input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      func      <= 2'($urandom);
      sample    <= sample_t'($urandom);
      @(negedge clk);
    end
    req_valid <= 1'b1;
    func      <= f;
    sample    <= s;
    do @(posedge clk); while (req_stall);
    if (f != FUNC_UNUSED) requests_sent++;
  endtask

  // Lower valid and hold off until every outstanding result has been taken.
  task automatic drain_outputs;
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_outputs != 0) @(negedge clk);
  endtask

  // Single request of any kind: mostly filtering, now and then a clear or
  // the unused code, with samples at the rails, near zero or anywhere.
  task automatic send_noise;
    int         pick;
    logic [1:0] f;
    sample_t    s;
    pick = $urandom_range(15);
    if (pick == 0)      f = FUNC_CLEAR;
    else if (pick == 1) f = FUNC_UNUSED;
    else                f = pick[0] ? FUNC_RED : FUNC_IR;
    case ($urandom_range(3))
      0:       s = sample_t'($urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN);
      1:       s = sample_t'(int'($urandom_range(2000)) - 1000);
      default: s = sample_t'($urandom);
    endcase
    send_request(f, s);
  endtask

  // Fill every tap of one channel so that each rail lines up with the sign
  // of its weight: the sum overshoots and the output must saturate. Feed the
  // oldest sample first, as it ends on the last tap. The other channel may
  // butt in now and then; its history is separate.
  task automatic send_saturating_burst(input logic chan, input logic upward);
    int   k;
    logic high;
    for (k = TAP_COUNT_DEF - 1; k >= 0; k--) begin
      high = (k >= POS_TAP_FIRST && k <= POS_TAP_LAST) ^ !upward;
      send_request(chan ? FUNC_RED : FUNC_IR,
                   sample_t'(high ? SAMPLE_MAX : SAMPLE_MIN));
      if ($urandom_range(7) == 0)
        send_request(chan ? FUNC_IR : FUNC_RED, sample_t'($urandom));
    end
  endtask

  // Pulse-like random walk on one channel; a zero step gives a held level,
  // i.e. a step response once the history has filled.
  task automatic send_waveform(input logic chan);
    int len;
    int level;
    int amp;
    len   = $urandom_range(12, 60);
    level = ($urandom_range(3) == 0) ? ($urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN)
                                     : int'($urandom_range(SAMPLE_MAX - SAMPLE_MIN)) + SAMPLE_MIN;
    amp   = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(4, 18));
    repeat (len) begin
      level += int'($urandom_range(2 * amp)) - amp;
      if (level > SAMPLE_MAX) level = SAMPLE_MAX;
      if (level < SAMPLE_MIN) level = SAMPLE_MIN;
      send_request(chan ? FUNC_RED : FUNC_IR, sample_t'(level));
    end
  endtask

  task automatic run_phase(input int target);
    int start;
    start = requests_sent;
    while (requests_sent - start < target) begin
      case ($urandom_range(9))
        0, 1, 2:    repeat ($urandom_range(1, 8)) send_noise();
        3, 4:       send_saturating_burst(1'($urandom_range(1)), 1'($urandom_range(1)));
        5, 6, 7, 8: send_waveform(1'($urandom_range(1)));
        default:    send_request(FUNC_CLEAR, sample_t'($urandom));
      endcase
    end
  endtask

  initial begin
    // phase one: sender idles a quarter of the time, receiver stalls heavily
    send_idle_pct  = 25;
    recv_stall_pct = 81;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero history after reset, both rails on both channels,
    // clear and the unused code with loud samples, alternating bit patterns
    send_request(FUNC_IR,     '0);
    send_request(FUNC_IR,     sample_t'(SAMPLE_MAX));
    send_request(FUNC_IR,     sample_t'(SAMPLE_MIN));
    send_request(FUNC_RED,    sample_t'(SAMPLE_MIN));
    send_request(FUNC_RED,    sample_t'(SAMPLE_MAX));
    send_request(FUNC_RED,    sample_t'(1));
    send_request(FUNC_IR,     sample_t'(-1));
    send_request(FUNC_UNUSED, sample_t'(SAMPLE_MAX));
    send_request(FUNC_IR,     sample_t'(20'h55555));
    send_request(FUNC_CLEAR,  sample_t'(SAMPLE_MIN));
    send_request(FUNC_IR,     sample_t'(SAMPLE_MAX));
    send_request(FUNC_RED,    sample_t'(-1));
    send_request(FUNC_UNUSED, sample_t'(SAMPLE_MIN));
    send_request(FUNC_RED,    sample_t'(20'hAAAAA));
    send_request(FUNC_IR,     sample_t'(20'hAAAAA));
    send_request(FUNC_RED,    sample_t'(20'h55555));

    run_phase(PHASE_REQUESTS);
    drain_outputs();

    // phase two: the other way round
    send_idle_pct  = 81;
    recv_stall_pct = 25;
    run_phase(PHASE_REQUESTS);
    drain_outputs();

    // phase three: back to back on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(PHASE_REQUESTS);
    drain_outputs();

    // allow a stray late result to show up before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
